/* design/vetp_pkg.sv */
package vetp_pkg;

  localparam logic [31:0] MAGIC_WORD       = 32'h564C_5431;  // "VLT1", first byte high
  localparam logic [6:0]  LOW7             = 7'h7F;
  localparam int unsigned CONT_BIT         = 7;              // bit of 0x80
  localparam logic [6:0]  SHIFT_STEP       = 7'd7;
  localparam logic [3:0]  MAX_VARINT_BYTES = 4'd10;
  localparam logic [3:0]  MAGIC_BYTES      = 4'd4;
  localparam logic [3:0]  ID_BYTES         = 4'd2;
  localparam logic [3:0]  COUNT_BYTES      = 4'd4;
  localparam logic [3:0]  LEN_BYTES        = 4'd2;

  localparam int unsigned TDATA_W = 208;  // 202 field bits padded to bytes

  typedef enum logic [3:0] {
    PH_MAGIC   = 4'd0,
    PH_ID      = 4'd1,
    PH_COUNT   = 4'd2,
    PH_TAG     = 4'd3,
    PH_DELTA   = 4'd4,
    PH_LEN     = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_DONE    = 4'd7,
    PH_ERROR   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_EVENT   = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_BAD_MAGIC  = 2'd0,
    ERR_TRUNCATED  = 2'd1,
    ERR_VARINT_LEN = 2'd2
  } err_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] tape_id;
    logic [31:0] event_count;
    logic [63:0] tag;
    logic [63:0] delta;
    logic [15:0] payload_len;
    logic [7:0]  payload_byte;
    logic [1:0]  error_code;
    logic        tape_done;
  } result_t;

endpackage

/* design/varint_event_tape_parser.sv */
// Channel  Dir  tdata fields (low bit up)                        tuser       tlast
// s_axis   in   data_byte[7:0]                                   action      -
// m_axis   out  tape_id, event_count, tag, delta, payload_len,   kind[1:0]   tape_done
//               payload_byte, error_code, 6 zero pad bits
//
// One input transfer per cycle while s_axis_tready is high; the decoder updates
// its parse state in the cycle of the transfer and its result is registered,
// in the output register or, when the output is stalled, in the skid slot.
// Synchronous reset puts the parser back to awaiting the magic word.
// The output register plus a one-entry skid slot absorb a stall: s_axis_tready
// drops only once both are holding results.
module varint_event_tape_parser (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  logic         s_axis_tuser,   // [0] action: 1 = end of input
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [207:0] m_axis_tdata,   // tape_id[15:0], event_count[47:16], tag[111:48],
                                       // delta[175:112], payload_len[191:176],
                                       // payload_byte[199:192], error_code[201:200]
  output logic [1:0]   m_axis_tuser,   // [1:0] kind
  output logic         m_axis_tlast    // tape_done
);
  import vetp_pkg::*;

  logic    take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // input transfer
  assign take = s_axis_tvalid && s_axis_tready;

  vetp_decoder u_dec (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .action    (s_axis_tuser),
    .data_byte (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  vetp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .room      (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  // pack fields, first field lowest
  assign m_axis_tdata = {6'b0, out_res.error_code, out_res.payload_byte, out_res.payload_len,
                         out_res.delta, out_res.tag, out_res.event_count, out_res.tape_id};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.tape_done;

endmodule

/* design/vetp_decoder.sv */
module vetp_decoder (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,       // input transfer this cycle
  input  logic              action,     // 1 = end of input
  input  logic [7:0]        data_byte,
  output logic              res_valid,
  output vetp_pkg::result_t res
);
  import vetp_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  byte_pos, byte_pos_next;
  logic [63:0] vacc, vacc_next;
  logic [31:0] hacc, hacc_next;
  logic [15:0] tape_id, tape_id_next;
  logic [31:0] events_rem, events_rem_next;
  logic [63:0] held_tag, held_tag_next;
  logic [63:0] held_delta, held_delta_next;
  logic [15:0] pay_rem, pay_rem_next;

  logic [3:0]  pos_inc;
  logic [6:0]  shamt;
  logic [63:0] vacc_or;
  logic [31:0] hacc_sh;
  logic [15:0] len_sh;
  logic [15:0] pay_dec;
  logic [31:0] events_dec;

  assign pos_inc    = byte_pos + 4'd1;
  assign shamt      = 7'(byte_pos) * SHIFT_STEP;
  assign vacc_or    = vacc | (64'(data_byte & {1'b0, LOW7}) << shamt);
  assign hacc_sh    = {hacc[23:0], data_byte};
  assign len_sh     = {pay_rem[7:0], data_byte};
  assign pay_dec    = pay_rem - 16'd1;
  assign events_dec = events_rem - 32'd1;

  always_comb begin
    phase_next      = phase;
    byte_pos_next   = byte_pos;
    vacc_next       = vacc;
    hacc_next       = hacc;
    tape_id_next    = tape_id;
    events_rem_next = events_rem;
    held_tag_next   = held_tag;
    held_delta_next = held_delta;
    pay_rem_next    = pay_rem;
    res_valid       = 1'b0;
    res             = '0;

    if (take) begin
      if (action) begin
        // end of input: re-arm, flag truncation unless finished or failed
        phase_next      = PH_MAGIC;
        byte_pos_next   = '0;
        vacc_next       = '0;
        hacc_next       = '0;
        tape_id_next    = '0;
        events_rem_next = '0;
        held_tag_next   = '0;
        held_delta_next = '0;
        pay_rem_next    = '0;
        if (phase != PH_DONE && phase != PH_ERROR) begin
          res_valid      = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_TRUNCATED;
        end
      end else begin
        unique case (phase) inside
          PH_MAGIC: begin
            hacc_next     = hacc_sh;
            byte_pos_next = pos_inc;
            if (pos_inc >= MAGIC_BYTES) begin
              byte_pos_next = '0;
              if (hacc_sh != MAGIC_WORD) begin
                phase_next     = PH_ERROR;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_BAD_MAGIC;
              end else begin
                hacc_next  = '0;
                phase_next = PH_ID;
              end
            end
          end
          PH_ID: begin
            tape_id_next  = {tape_id[7:0], data_byte};
            byte_pos_next = pos_inc;
            if (pos_inc >= ID_BYTES) begin
              byte_pos_next = '0;
              hacc_next     = '0;
              phase_next    = PH_COUNT;
            end
          end
          PH_COUNT: begin
            hacc_next     = hacc_sh;
            byte_pos_next = pos_inc;
            if (pos_inc >= COUNT_BYTES) begin
              byte_pos_next   = '0;
              events_rem_next = hacc_sh;
              res_valid       = 1'b1;
              res.kind        = KIND_HEADER;
              res.tape_id     = tape_id;
              res.event_count = hacc_sh;
              if (hacc_sh == '0) begin
                phase_next    = PH_DONE;
                res.tape_done = 1'b1;
              end else begin
                phase_next = PH_TAG;
                vacc_next  = '0;
              end
            end
          end
          PH_TAG, PH_DELTA: begin
            if (byte_pos >= MAX_VARINT_BYTES) begin
              phase_next     = PH_ERROR;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_VARINT_LEN;
            end else begin
              vacc_next = vacc_or;
              if (!data_byte[CONT_BIT]) begin
                if (phase == PH_TAG) begin
                  held_tag_next = vacc_or;
                  phase_next    = PH_DELTA;
                end else begin
                  // zigzag: (z >> 1) ^ -(z & 1)
                  held_delta_next = {1'b0, vacc_or[63:1]} ^ {64{vacc_or[0]}};
                  phase_next      = PH_LEN;
                  pay_rem_next    = '0;
                end
                vacc_next     = '0;
                byte_pos_next = '0;
              end else if (pos_inc >= MAX_VARINT_BYTES) begin
                phase_next     = PH_ERROR;
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_VARINT_LEN;
              end else begin
                byte_pos_next = pos_inc;
              end
            end
          end
          PH_LEN: begin
            pay_rem_next  = len_sh;
            byte_pos_next = pos_inc;
            if (pos_inc >= LEN_BYTES) begin
              byte_pos_next   = '0;
              res_valid       = 1'b1;
              res.kind        = KIND_EVENT;
              res.tag         = held_tag;
              res.delta       = held_delta;
              res.payload_len = len_sh;
              if (len_sh == '0) begin
                events_rem_next = events_dec;
                vacc_next       = '0;
                if (events_dec == '0) begin
                  phase_next    = PH_DONE;
                  res.tape_done = 1'b1;
                end else begin
                  phase_next = PH_TAG;
                end
              end else begin
                phase_next = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            res_valid        = 1'b1;
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = data_byte;
            pay_rem_next     = pay_dec;
            if (pay_dec == '0) begin
              events_rem_next = events_dec;
              vacc_next       = '0;
              if (events_dec == '0) begin
                phase_next    = PH_DONE;
                res.tape_done = 1'b1;
              end else begin
                phase_next = PH_TAG;
              end
            end
          end
          default: begin
            // done or error: data bytes dropped
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MAGIC;
      byte_pos   <= '0;
      vacc       <= '0;
      hacc       <= '0;
      tape_id    <= '0;
      events_rem <= '0;
      held_tag   <= '0;
      held_delta <= '0;
      pay_rem    <= '0;
    end else begin
      phase      <= phase_next;
      byte_pos   <= byte_pos_next;
      vacc       <= vacc_next;
      hacc       <= hacc_next;
      tape_id    <= tape_id_next;
      events_rem <= events_rem_next;
      held_tag   <= held_tag_next;
      held_delta <= held_delta_next;
      pay_rem    <= pay_rem_next;
    end
  end

endmodule

/* design/vetp_out_stage.sv */
module vetp_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vetp_pkg::result_t push_data,
  output logic              room,
  output logic              out_valid,
  input  logic              out_ready,
  output vetp_pkg::result_t out_data
);
  import vetp_pkg::*;

  result_t skid_data;
  logic    skid_valid;
  logic    pop;

  assign room = !skid_valid;
  assign pop  = out_valid && out_ready;

  // push only arrives while the skid slot is empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (!out_valid || pop) begin
      out_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* design/vetp_checker.sv */
module vetp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [207:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser,
  input logic         m_axis_tlast
);
  import vetp_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // an error never completes a tape
  a_done_kind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser != KIND_ERROR)
    else $error("tape_done on error result");

  // error results carry only a legal code
  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_ERROR |->
      m_axis_tdata[199:0] == '0 && m_axis_tdata[201:200] != 2'd3)
    else $error("malformed error result");

  // reset empties the output side and opens the input
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("not empty after reset");

endmodule

bind varint_event_tape_parser vetp_checker u_vetp_checker (.*);

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vetp_pkg::*;

  localparam int RANDOM_ITEMS = 460;
  localparam int MAX_GAP      = 18;
  localparam int HOLD_OFF     = 400;     // long receiver stall for the backpressure test
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int SHOW_LIMIT   = 10;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic         s_axis_tuser = 1'b0;    // [0] action: 1 = end of input
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;           // tape_id, event_count, tag, delta, payload_len,
                                        // payload_byte, error_code, pad
  logic [1:0]   m_axis_tuser;           // [1:0] kind
  logic         m_axis_tlast;           // tape_done

  varint_event_tape_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // Run bookkeeping
  int      cycle_count = 0;
  int      fail_count  = 0;
  int      items_sent  = 0;
  int      hold_req    = 0;     // set by the backpressure test, consumed by the sink
  bit      src_calm    = 1'b0;  // no sender gaps while set
  bit      src_rush    = 1'b0;  // forced back-to-back sending
  bit      sink_calm   = 1'b0;  // no receiver stalls while set
  result_t expected_q[$];       // parse results still owed by the block
  logic [7:0] tape_q[$];        // tape under construction

  // Parser mirror: tracks where the tape parse stands
  phase_t      ph;
  logic [3:0]  pos;
  logic [63:0] vacc;
  logic [31:0] hacc;
  logic [15:0] tid;
  logic [31:0] evleft;
  logic [63:0] tag_hold;
  logic [63:0] delta_hold;
  logic [15:0] payleft;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  function automatic void rearm_parser();
    ph         = PH_MAGIC;
    pos        = '0;
    vacc       = '0;
    hacc       = '0;
    tid        = '0;
    evleft     = '0;
    tag_hold   = '0;
    delta_hold = '0;
    payleft    = '0;
  endfunction

  // Closes one event; returns the tape_done flag.
  function automatic logic close_event();
    evleft = evleft - 32'd1;
    if (evleft == 0) begin
      ph = PH_DONE;
      return 1'b1;
    end
    ph = PH_TAG;
    return 1'b0;
  endfunction

  // Advance the mirror by one accepted transfer and queue any result it owes.
  function automatic void parse_byte(input logic eoi, input logic [7:0] b);
    result_t r;
    logic    owed;
    r    = '0;
    owed = 1'b0;
    if (eoi) begin
      // end of input before completion is a truncation; after done/error it just re-arms
      if (ph != PH_DONE && ph != PH_ERROR) begin
        owed         = 1'b1;
        r.kind       = KIND_ERROR;
        r.error_code = ERR_TRUNCATED;
      end
      rearm_parser();
    end else begin
      case (ph) inside
        PH_MAGIC: begin
          hacc = {hacc[23:0], b};
          pos  = pos + 4'd1;
          if (pos >= MAGIC_BYTES) begin
            pos = '0;
            if (hacc != MAGIC_WORD) begin
              ph           = PH_ERROR;
              owed         = 1'b1;
              r.kind       = KIND_ERROR;
              r.error_code = ERR_BAD_MAGIC;
            end else begin
              hacc = '0;
              ph   = PH_ID;
            end
          end
        end
        PH_ID: begin
          tid = {tid[7:0], b};
          pos = pos + 4'd1;
          if (pos >= ID_BYTES) begin
            pos  = '0;
            hacc = '0;
            ph   = PH_COUNT;
          end
        end
        PH_COUNT: begin
          hacc = {hacc[23:0], b};
          pos  = pos + 4'd1;
          if (pos >= COUNT_BYTES) begin
            pos           = '0;
            evleft        = hacc;
            owed          = 1'b1;
            r.kind        = KIND_HEADER;
            r.tape_id     = tid;
            r.event_count = evleft;
            if (evleft == 0) begin
              ph          = PH_DONE;
              r.tape_done = 1'b1;
            end else begin
              ph   = PH_TAG;
              vacc = '0;
            end
          end
        end
        PH_TAG, PH_DELTA: begin
          // bits shifted past 63 fall off
          vacc = vacc | ({57'd0, b[6:0] & LOW7} << (pos * SHIFT_STEP));
          if (!b[CONT_BIT]) begin
            if (ph == PH_TAG) begin
              tag_hold = vacc;
              ph       = PH_DELTA;
            end else begin
              delta_hold = (vacc >> 1) ^ {64{vacc[0]}};
              ph         = PH_LEN;
              payleft    = '0;
            end
            vacc = '0;
            pos  = '0;
          end else if (pos + 4'd1 >= MAX_VARINT_BYTES) begin
            ph           = PH_ERROR;
            owed         = 1'b1;
            r.kind       = KIND_ERROR;
            r.error_code = ERR_VARINT_LEN;
          end else begin
            pos = pos + 4'd1;
          end
        end
        PH_LEN: begin
          payleft = {payleft[7:0], b};
          pos     = pos + 4'd1;
          if (pos >= LEN_BYTES) begin
            pos           = '0;
            owed          = 1'b1;
            r.kind        = KIND_EVENT;
            r.tag         = tag_hold;
            r.delta       = delta_hold;
            r.payload_len = payleft;
            if (payleft == 0) begin
              r.tape_done = close_event();
              vacc        = '0;
            end else begin
              ph = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          owed           = 1'b1;
          r.kind         = KIND_PAYLOAD;
          r.payload_byte = b;
          payleft        = payleft - 16'd1;
          if (payleft == 0) begin
            r.tape_done = close_event();
            vacc        = '0;
          end
        end
        default: ;  // done or error: data bytes are dropped
      endcase
    end
    if (owed) expected_q = {expected_q, r};
  endfunction

  // One input transfer, with a random lead-in gap.
  task automatic send_item(input logic eoi, input logic [7:0] b);
    int gap;
    if ($urandom_range(0, 49) == 0) src_calm = !src_calm;
    gap = (src_calm || src_rush) ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= eoi;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    parse_byte(eoi, b);
    items_sent++;
  endtask

  // Tape assembly helpers
  function automatic void put_byte(input logic [7:0] b);
    tape_q = {tape_q, b};
  endfunction

  function automatic void put_be16(input logic [15:0] v);
    put_byte(v[15:8]);
    put_byte(v[7:0]);
  endfunction

  function automatic void put_be32(input logic [31:0] v);
    put_be16(v[31:16]);
    put_be16(v[15:0]);
  endfunction

  function automatic void put_header(input logic [15:0] id, input logic [31:0] count);
    put_be32(MAGIC_WORD);
    put_be16(id);
    put_be32(count);
  endfunction

  // canonical LEB128
  function automatic void put_varint(input logic [63:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 0) b[CONT_BIT] = 1'b1;
      put_byte(b);
    end while (v != 0);
  endfunction

  // random varint bytes: mostly short, some full length, a few overlong
  function automatic void put_rand_varint();
    int n;
    int k;
    int i;
    k = $urandom_range(0, 99);
    n = (k < 60) ? 1 : (k < 85) ? $urandom_range(2, 4) : (k < 97) ? $urandom_range(5, 10) : 11;
    for (i = 0; i < n; i++) put_byte({i < n - 1, 7'($urandom)});
  endfunction

  task automatic flush_tape();
    while (tape_q.size() != 0) send_item(1'b0, tape_q.pop_front());
  endtask

  task automatic end_input();
    send_item(1'b1, 8'($urandom));
  endtask

  // Result checker
  function automatic string show(input result_t r);
    return $sformatf("kind=%0d id=%h cnt=%h tag=%h delta=%0d len=%h byte=%h err=%0d done=%b",
                     r.kind, r.tape_id, r.event_count, r.tag, $signed(r.delta),
                     r.payload_len, r.payload_byte, r.error_code, r.tape_done);
  endfunction

  task automatic log_mismatch(input string why, input result_t want, input result_t seen);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) begin
      $display("mismatch (%s) at cycle %0d", why, cycle_count);
      $display("  expected %s", show(want));
      $display("  actual   %s", show(seen));
    end
  endtask

  always @(posedge clk) begin : result_monitor
    result_t seen;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.kind         = m_axis_tuser;
      seen.tape_id      = m_axis_tdata[15:0];
      seen.event_count  = m_axis_tdata[47:16];
      seen.tag          = m_axis_tdata[111:48];
      seen.delta        = m_axis_tdata[175:112];
      seen.payload_len  = m_axis_tdata[191:176];
      seen.payload_byte = m_axis_tdata[199:192];
      seen.error_code   = m_axis_tdata[201:200];
      seen.tape_done    = m_axis_tlast;
      if (expected_q.size() == 0) begin
        log_mismatch("no result expected", '0, seen);
      end else begin
        want = expected_q.pop_front();
        if (seen !== want) log_mismatch("field", want, seen);
      end
    end
  end

  // Result sink: random stalls, calm stretches, and one long hold-off on request
  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      if (hold_req != 0) begin
        stall = hold_req;
        m_axis_tready <= 1'b0;
        hold_req      <= 0;
        repeat (stall) @(posedge clk);
      end
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
      stall = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid && hold_req == 0) @(posedge clk);
    end
  end

  // Zero events: header itself closes the tape; stray bytes after it are ignored.
  // Then an empty tape, which is a truncation.
  task automatic test_zero_event_tape();
    put_header(16'hFFFF, 32'd0);
    put_byte(8'hAB);
    flush_tape();
    end_input();
    end_input();
  endtask

  // Fourth magic byte wrong; later bytes dropped until end of input.
  task automatic test_bad_magic();
    put_be32({MAGIC_WORD[31:8], 8'h32});
    put_byte(8'h00);
    flush_tape();
    end_input();
  endtask

  // Tag and delta extremes, zero and short payloads, tape closed by an event result.
  task automatic test_event_extremes();
    int i;
    put_header(16'h0000, 32'd4);
    put_varint(64'hFFFF_FFFF_FFFF_FFFF);   // largest tag
    put_varint(64'hFFFF_FFFF_FFFF_FFFF);   // zigzag -> most negative delta
    put_be16(16'd0);
    put_byte(8'h00);                       // tag 0
    put_varint(64'hFFFF_FFFF_FFFF_FFFE);   // zigzag -> most positive delta
    put_be16(16'd2);
    put_byte(8'h00);
    put_byte(8'hFF);
    for (i = 0; i < 9; i++) put_byte(8'hFF);
    put_byte(8'h7F);                       // tenth byte: bits past 63 dropped
    put_byte(8'h80);                       // delta 0, non-canonical
    put_byte(8'h00);
    put_be16(16'd1);
    put_byte(8'h5A);
    put_varint(64'd1);
    put_varint(64'd1);                     // delta -1
    put_be16(16'd0);                       // last event closes on its event result
    flush_tape();
    end_input();
  endtask

  // Tenth varint byte with its continuation bit set.
  task automatic test_long_varint();
    put_header(16'h1234, 32'd1);
    repeat (10) put_byte(8'h80);
    put_byte(8'h01);
    flush_tape();
    end_input();
  endtask

  // End of input in the middle of the final payload.
  task automatic test_short_payload();
    put_header(16'h8001, 32'd1);
    put_varint(64'd5);
    put_varint(64'd4);
    put_be16(16'd3);
    put_byte(8'h11);
    put_byte(8'h22);
    flush_tape();
    end_input();
  endtask

  // Receiver holds off while the sender streams a long payload back to back.
  task automatic test_backpressure();
    int i;
    src_rush = 1'b1;
    hold_req <= HOLD_OFF;
    put_header(16'h5555, 32'd1);
    put_varint(64'd300);
    put_varint(64'd7);
    put_be16(16'd150);
    for (i = 0; i < 150; i++) put_byte(8'($urandom));
    flush_tape();
    end_input();
    src_rush = 1'b0;
  endtask

  // One random tape: mostly well formed, some corrupt, truncated or plain noise.
  task automatic random_tape();
    int          shape;
    int          n_events;
    int          plen;
    int          k;
    int          e;
    int          cut;
    int          at;
    logic [31:0] announced;
    shape = $urandom_range(0, 99);
    if (shape < 5) begin
      repeat ($urandom_range(1, 12)) put_byte(8'($urandom));
    end else begin
      put_be32(MAGIC_WORD);
      if (shape < 10) begin
        at = $urandom_range(0, 3);
        tape_q[at] = tape_q[at] ^ 8'($urandom_range(1, 255));
      end
      put_be16(16'($urandom));
      n_events  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      announced = (shape < 15) ? 32'($urandom) : 32'(n_events);
      put_be32(announced);
      for (e = 0; e < n_events; e++) begin
        put_rand_varint();
        put_rand_varint();
        k    = $urandom_range(0, 99);
        plen = (k < 30) ? 0 : (k < 90) ? $urandom_range(1, 6) :
               (k < 97) ? $urandom_range(7, 24) : $urandom_range(0, 65535);
        put_be16(16'(plen));
        if (plen > 24) plen = $urandom_range(0, 8);  // huge length: cut short by end of input
        repeat (plen) put_byte(8'($urandom));
      end
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
      if (shape >= 15 && shape < 27) begin
        cut = $urandom_range(0, tape_q.size() - 1);
        while (tape_q.size() > cut) void'(tape_q.pop_back());
      end
    end
    flush_tape();
    end_input();
    if ($urandom_range(0, 19) == 0) end_input();
  endtask

  task automatic test_random_tapes();
    int start;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) random_tape();
  endtask

  initial begin
    rearm_parser();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_zero_event_tape();
    test_bad_magic();
    test_event_extremes();
    test_long_varint();
    test_short_payload();
    test_backpressure();
    test_random_tapes();

    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
design/vetp_pkg.sv
design/vetp_decoder.sv
design/vetp_out_stage.sv
design/varint_event_tape_parser.sv
design/vetp_checker.sv
tb/testbench.sv
